### rtl/pfa_pkg.sv
// Shared types and constants for the partition fit allocator.
// No dependencies; used by pfa_ctrl and partition_fit_allocator_unit.
package pfa_pkg;

   localparam int INDEX_BITS = 5;
   localparam int COUNT_BITS = 6;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PARTITION_COUNT = 2'd0,
      CSR_FIT_POLICY      = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_WORST = 2'd2,
      POL_NEXT  = 2'd3
   } policy_type;

   typedef enum logic [0:0] {
      KIND_LOAD    = 1'b0,
      KIND_REQUEST = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      policy_type            policy;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      kind_type              kind;
      logic [INDEX_BITS-1:0] index;
   } item_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } status_type;

endpackage

### rtl/pfa_table.sv
// Free-size table: one synchronous memory, one write and one read port.
// Read data is registered. No package dependency.
module pfa_table #(
   parameter int DEPTH     = 32,
   parameter int SIZE_BITS = 16,
   parameter int ADDR_W    = 5
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [SIZE_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [SIZE_BITS-1:0] rd_data
);

   logic [SIZE_BITS-1:0] mem [DEPTH];
   logic [SIZE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/pfa_ctrl.sv
// Allocation sequencer: scans the free-size table one entry per cycle,
// tracks the candidate for the placement rule and writes the result back.
// Depends on pfa_pkg; drives pfa_table.
module pfa_ctrl #(
   parameter int DEPTH     = 32,
   parameter int SIZE_BITS = 16,
   parameter int ADDR_W    = 5
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pfa_pkg::cfg_type                       cfg,
   input  pfa_pkg::item_ctl_type                  item,
   input  logic [SIZE_BITS-1:0]                   item_size,
   input  logic                                   take,
   output pfa_pkg::status_type                    status,
   output logic                                   res_granted,
   output logic [pfa_pkg::INDEX_BITS-1:0]         res_chosen,
   output logic [SIZE_BITS-1:0]                   res_before,
   output logic [SIZE_BITS-1:0]                   res_after,
   output logic                                   wr_en,
   output logic [ADDR_W-1:0]                      wr_addr,
   output logic [SIZE_BITS-1:0]                   wr_data,
   output logic                                   rd_en,
   output logic [ADDR_W-1:0]                      rd_addr,
   input  logic [SIZE_BITS-1:0]                   rd_data
);

   localparam logic [pfa_pkg::COUNT_BITS-1:0] DEPTH_C = pfa_pkg::COUNT_BITS'(DEPTH);
   localparam logic [8:0] LOAD_LIM = 9'(DEPTH);

   pfa_pkg::state_type state_ff, state_in;

   logic [SIZE_BITS-1:0]               req_ff, req_in;
   logic [pfa_pkg::COUNT_BITS-1:0]     n_ff, n_in;
   logic [pfa_pkg::COUNT_BITS-1:0]     issue_cnt_ff, issue_cnt_in;
   logic [ADDR_W-1:0]                  addr_ff, addr_in;
   logic                               rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]                  rd_addr_ff, rd_addr_in;
   logic                               pick_valid_ff, pick_valid_in;
   logic [ADDR_W-1:0]                  pick_ff, pick_in;
   logic [SIZE_BITS-1:0]               pick_free_ff, pick_free_in;
   logic [ADDR_W-1:0]                  ptr_ff, ptr_in;
   logic                               granted_ff, granted_in;
   logic [pfa_pkg::INDEX_BITS-1:0]     chosen_ff, chosen_in;
   logic [SIZE_BITS-1:0]               before_ff, before_in;
   logic [SIZE_BITS-1:0]               after_ff, after_in;

   logic [pfa_pkg::COUNT_BITS-1:0] n_c;
   logic                           issue;
   logic                           fits;
   logic                           take_pick;
   logic                           grant_c;
   logic                           load_wr;
   logic [SIZE_BITS-1:0]           remain_c;
   logic [ADDR_W-1:0]              pick_next_c;

   assign n_c       = (cfg.count > DEPTH_C) ? DEPTH_C : cfg.count;
   assign issue     = (state_ff == pfa_pkg::ST_SCAN) && (issue_cnt_ff < n_ff);
   assign fits      = (req_ff <= rd_data);
   assign grant_c   = pick_valid_ff && (req_ff <= pick_free_ff);
   assign remain_c  = pick_free_ff - req_ff;
   assign load_wr   = item.start && (item.kind == pfa_pkg::KIND_LOAD) &&
                      ({4'b0, item.index} < LOAD_LIM);
   assign pick_next_c = ((pfa_pkg::COUNT_BITS'(pick_ff) + 6'd1) >= n_ff) ?
                        '0 : ADDR_W'(pick_ff + 1'b1);

   always_comb begin
      case (cfg.policy)
         pfa_pkg::POL_BEST:  take_pick = fits && (!pick_valid_ff || rd_data < pick_free_ff);
         pfa_pkg::POL_WORST: take_pick = !pick_valid_ff || rd_data > pick_free_ff;
         default:            take_pick = fits && !pick_valid_ff;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            if (item.start) begin
               state_in = (item.kind == pfa_pkg::KIND_LOAD) ? pfa_pkg::ST_DONE
                                                            : pfa_pkg::ST_SCAN;
            end
         end
         pfa_pkg::ST_SCAN: begin
            if (!issue && !rd_valid_ff) begin
               state_in = pfa_pkg::ST_WRITE;
            end
         end
         pfa_pkg::ST_WRITE: state_in = pfa_pkg::ST_DONE;
         pfa_pkg::ST_DONE: begin
            if (take) begin
               state_in = pfa_pkg::ST_IDLE;
            end
         end
         default: state_in = pfa_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      wr_en       = 1'b0;
      wr_addr     = pick_ff;
      wr_data     = remain_c;
      rd_en       = 1'b0;
      status.idle = 1'b0;
      status.done = 1'b0;
      unique case (state_ff)
         pfa_pkg::ST_IDLE: begin
            status.idle = 1'b1;
            wr_en       = load_wr;
            wr_addr     = item.index[ADDR_W-1:0];
            wr_data     = item_size;
         end
         pfa_pkg::ST_SCAN:  rd_en = issue;
         pfa_pkg::ST_WRITE: wr_en = grant_c;
         pfa_pkg::ST_DONE:  status.done = 1'b1;
         default: ;
      endcase
   end

   assign rd_addr = addr_ff;

   // datapath next values
   always_comb begin
      req_in        = req_ff;
      n_in          = n_ff;
      issue_cnt_in  = issue_cnt_ff;
      addr_in       = addr_ff;
      rd_valid_in   = issue;
      rd_addr_in    = addr_ff;
      pick_valid_in = pick_valid_ff;
      pick_in       = pick_ff;
      pick_free_in  = pick_free_ff;
      ptr_in        = ptr_ff;
      granted_in    = granted_ff;
      chosen_in     = chosen_ff;
      before_in     = before_ff;
      after_in      = after_ff;

      if (state_ff == pfa_pkg::ST_IDLE && item.start) begin
         req_in        = item_size;
         n_in          = n_c;
         issue_cnt_in  = '0;
         pick_valid_in = 1'b0;
         addr_in       = (cfg.policy == pfa_pkg::POL_NEXT &&
                          pfa_pkg::COUNT_BITS'(ptr_ff) < n_c) ? ptr_ff : '0;
         granted_in    = 1'b0;
         chosen_in     = '0;
         before_in     = '0;
         after_in      = '0;
      end

      if (issue) begin
         issue_cnt_in = issue_cnt_ff + 6'd1;
         addr_in      = ((pfa_pkg::COUNT_BITS'(addr_ff) + 6'd1) >= n_ff) ?
                        '0 : ADDR_W'(addr_ff + 1'b1);
      end

      if (rd_valid_ff && take_pick) begin
         pick_valid_in = 1'b1;
         pick_in       = rd_addr_ff;
         pick_free_in  = rd_data;
      end

      if (state_ff == pfa_pkg::ST_WRITE && grant_c) begin
         granted_in = 1'b1;
         chosen_in  = pfa_pkg::INDEX_BITS'(pick_ff);
         before_in  = pick_free_ff;
         after_in   = remain_c;
         if (cfg.policy == pfa_pkg::POL_NEXT) begin
            ptr_in = pick_next_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pfa_pkg::ST_IDLE;
         rd_valid_ff   <= 1'b0;
         pick_valid_ff <= 1'b0;
         ptr_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rd_valid_ff   <= rd_valid_in;
         pick_valid_ff <= pick_valid_in;
         ptr_ff        <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      n_ff         <= n_in;
      issue_cnt_ff <= issue_cnt_in;
      addr_ff      <= addr_in;
      rd_addr_ff   <= rd_addr_in;
      pick_ff      <= pick_in;
      pick_free_ff <= pick_free_in;
      granted_ff   <= granted_in;
      chosen_ff    <= chosen_in;
      before_ff    <= before_in;
      after_ff     <= after_in;
   end

   assign res_granted = granted_ff;
   assign res_chosen  = chosen_ff;
   assign res_before  = before_ff;
   assign res_after   = after_ff;

   a_rd_valid_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> state_ff == pfa_pkg::ST_SCAN)
      else $error("read data returned outside scan");

   a_issue_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfa_pkg::ST_SCAN |-> issue_cnt_ff <= n_ff)
      else $error("scan issued past searched count");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && rd_en))
      else $error("table write during scan");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      pfa_pkg::COUNT_BITS'(ptr_ff) < DEPTH_C)
      else $error("resume pointer out of range");

   a_after_le_before: assert property (@(posedge clock) disable iff (reset)
      state_ff == pfa_pkg::ST_DONE && granted_ff |-> after_ff <= before_ff)
      else $error("granted partition grew");

endmodule

### rtl/partition_fit_allocator_unit.sv
// Partition fit allocator: keeps a free size per partition in one memory and
// places each request by first, best, worst or next fit, one result word per
// input word. The scan reads one table entry per cycle through the memory's
// single read port; then the read latency drains, the remainder is written
// back if the request fits, the result is handed to the output register and
// the unit returns to idle.
// The result register lets the next word enter while a result waits.
// Depends on pfa_pkg, pfa_table and pfa_ctrl.
module partition_fit_allocator_unit #(
   parameter int PARTITIONS = 32,
   parameter int SIZE_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // partition_index[4:0], size_value[20:5], zero pad
   input  logic        req_tuser,    // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // chosen_partition[4:0], free_before[20:5],
                                     // free_after[36:21], zero pad
   output logic        rsp_tuser,    // granted
   input  logic                               csr_wr_en,
   input  logic [pfa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [5:0]                         csr_wdata
);

   localparam int DEPTH  = (PARTITIONS < 32) ? PARTITIONS : 32;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   pfa_pkg::cfg_type      cfg_ff, cfg_in;
   pfa_pkg::item_ctl_type item;
   pfa_pkg::status_type   status;

   logic [SIZE_BITS+15:0] size_ext;
   logic [SIZE_BITS-1:0]  item_size;
   logic                  take;

   logic                       res_granted;
   logic [pfa_pkg::INDEX_BITS-1:0] res_chosen;
   logic [SIZE_BITS-1:0]       res_before, res_after;
   logic [SIZE_BITS+15:0]      before_ext, after_ext;

   logic                       wr_en, rd_en;
   logic [ADDR_W-1:0]          wr_addr, rd_addr;
   logic [SIZE_BITS-1:0]       wr_data, rd_data;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // configuration
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            pfa_pkg::CSR_PARTITION_COUNT: cfg_in.count = csr_wdata;
            pfa_pkg::CSR_FIT_POLICY:      cfg_in.policy = pfa_pkg::policy_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.count  <= 6'd32;
         cfg_ff.policy <= pfa_pkg::POL_FIRST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input side
   assign req_tready = status.idle;
   assign size_ext   = {{SIZE_BITS{1'b0}}, req_tdata[20:5]};
   assign item_size  = size_ext[SIZE_BITS-1:0];
   assign item.start = req_tvalid && req_tready;
   assign item.kind  = pfa_pkg::kind_type'(req_tuser);
   assign item.index = req_tdata[4:0];

   pfa_table #(
      .DEPTH     (DEPTH),
      .SIZE_BITS (SIZE_BITS),
      .ADDR_W    (ADDR_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pfa_ctrl #(
      .DEPTH     (DEPTH),
      .SIZE_BITS (SIZE_BITS),
      .ADDR_W    (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .item        (item),
      .item_size   (item_size),
      .take        (take),
      .status      (status),
      .res_granted (res_granted),
      .res_chosen  (res_chosen),
      .res_before  (res_before),
      .res_after   (res_after),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data)
   );

   // result register
   assign before_ext = {16'b0, res_before};
   assign after_ext  = {16'b0, res_after};
   assign take       = status.done && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b0, after_ext[15:0], before_ext[15:0], res_chosen};
         rsp_user_in  = res_granted;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
